### src/dct_pkg.sv
// ---------------------------------------------------------------------------
// dct_pkg
// shared types and constants of the delayed coincidence tagger
// ---------------------------------------------------------------------------
`default_nettype none

package dct_pkg;

   // field widths of the item channels
   localparam int HITS_W     = 12;
   localparam int POS_W      = 14;
   localparam int IN_CLK_W   = 43;
   localparam int GAP_W      = 43;
   localparam int BACK_W     = 7;

   // register widths
   localparam int LIM_W      = 13;
   localparam int TICK_W     = 20;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 20;

   // packed event: valid, hits, x, y, z
   localparam int EVENT_W    = 1 + HITS_W + 3 * POS_W;

   // vector math: differences of two positions need one more bit
   localparam int VEC_W      = POS_W + 1;
   localparam int SQ_W       = 2 * POS_W;
   localparam int SUM_W      = SQ_W + 2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROMPT_HITS_MIN  = 4'd0,
      CSR_PROMPT_HITS_MAX  = 4'd1,
      CSR_DELAYED_HITS_MIN = 4'd2,
      CSR_DELAYED_HITS_MAX = 4'd3,
      CSR_RADIUS_LIMIT     = 4'd4,
      CSR_DISTANCE_LIMIT   = 4'd5,
      CSR_DELAY_MIN_TICKS  = 4'd6,
      CSR_DELAY_MAX_TICKS  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [HITS_W-1:0] prompt_hits_min;
      logic [HITS_W-1:0] prompt_hits_max;
      logic [HITS_W-1:0] delayed_hits_min;
      logic [HITS_W-1:0] delayed_hits_max;
      logic [LIM_W-1:0]  radius_limit;
      logic [LIM_W-1:0]  distance_limit;
      logic [TICK_W-1:0] delay_min_ticks;
      logic [TICK_W-1:0] delay_max_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prompt_hits_min:  12'd120,
      prompt_hits_max:  12'd680,
      delayed_hits_min: 12'd350,
      delayed_hits_max: 12'd600,
      radius_limit:     13'd5700,
      distance_limit:   13'd1500,
      delay_min_ticks:  20'd20,
      delay_max_ticks:  20'd40000
   };

   typedef struct packed {
      logic                    valid;
      logic [HITS_W-1:0]       hits;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } event_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } vec_type;

   // per-candidate flags travelling down the walk pipeline
   typedef struct packed {
      logic              valid;
      logic              beyond;
      logic              too_soon;
      logic              hits_ok;
      logic [HITS_W-1:0] hits;
   } cand_type;

endpackage

`default_nettype wire

### src/dct_req_if.sv
// ---------------------------------------------------------------------------
// dct_req_if
// input item channel: one detector event per item
// ---------------------------------------------------------------------------
`default_nettype none

interface dct_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  fit_valid;
   logic [dct_pkg::HITS_W-1:0]            hit_count;
   logic signed [dct_pkg::POS_W-1:0]      pos_x;
   logic signed [dct_pkg::POS_W-1:0]      pos_y;
   logic signed [dct_pkg::POS_W-1:0]      pos_z;
   logic [dct_pkg::IN_CLK_W-1:0]          clock_ticks;

   modport source (
      output valid, fit_valid, hit_count, pos_x, pos_y, pos_z, clock_ticks,
      input  ready
   );
   modport sink (
      input  valid, fit_valid, hit_count, pos_x, pos_y, pos_z, clock_ticks,
      output ready
   );
endinterface

`default_nettype wire

### src/dct_rsp_if.sv
// ---------------------------------------------------------------------------
// dct_rsp_if
// result item channel: tag and matched prompt of one event
// ---------------------------------------------------------------------------
`default_nettype none

interface dct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          delayed_passed;
   logic                          pair_found;
   logic [dct_pkg::GAP_W-1:0]     gap_ticks;
   logic [dct_pkg::BACK_W-1:0]    events_back;
   logic [dct_pkg::HITS_W-1:0]    prompt_hits;

   modport source (
      output valid, delayed_passed, pair_found, gap_ticks, events_back, prompt_hits,
      input  ready
   );
   modport sink (
      input  valid, delayed_passed, pair_found, gap_ticks, events_back, prompt_hits,
      output ready
   );
endinterface

`default_nettype wire

### src/delayed_coincidence_tagger_core.sv
// ---------------------------------------------------------------------------
// delayed_coincidence_tagger_core
// tags delayed events and searches the event history for a prompt partner
// ---------------------------------------------------------------------------
// usage
//   req: one detector event per item (fit flag, hit count, x/y/z in mm,
//        50 MHz clock count). rsp: one result item per event, in order.
//   csr: write enable, register index, data; write only while idle.
// operation
//   every event is stored in a ring memory of RING_DEPTH entries. an event
//   that passes the delayed cuts walks the ring backwards, newest first,
//   one entry read per cycle through the walk pipeline, and stops at the
//   first prompt partner, at a gap beyond the maximum delay, or after
//   min(stored events, SEARCH_LIMIT) entries.
// throughput
//   one item at a time: the next item is taken only after the result of
//   the last one is loaded; a walk reads the single ring read port.
// reset sets control and cut registers to defaults and empties the ring; no
// clearing pass is needed. a stalled receiver holds the result register; the
// next item is still accepted and worked on, and waits before its ring write.
// ---------------------------------------------------------------------------
`default_nettype none

module delayed_coincidence_tagger_core #(
   parameter int RING_DEPTH   = 128,
   parameter int SEARCH_LIMIT = 102,
   parameter int CLOCK_BITS   = 43
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   dct_req_if.sink                              req,
   dct_rsp_if.source                            rsp,
   input  wire logic                            csr_we,
   input  wire logic [dct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dct_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W  = $clog2(RING_DEPTH);
   localparam int CNT_MAX = (RING_DEPTH > SEARCH_LIMIT) ? RING_DEPTH : SEARCH_LIMIT;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int ENTRY_W = CLOCK_BITS + dct_pkg::EVENT_W;
   localparam int CMP_W   = (CLOCK_BITS > dct_pkg::TICK_W) ? CLOCK_BITS : dct_pkg::TICK_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CUT,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   dct_pkg::cfg_type               cfg_ff, cfg_in;

   // current event
   dct_pkg::event_type             cur_ev_ff, cur_ev_in;
   logic [CLOCK_BITS-1:0]          cur_clk_ff, cur_clk_in;

   // ring bookkeeping
   logic [ADDR_W-1:0]              wslot_ff, wslot_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [CNT_W-1:0]               limit_ff, limit_in;
   logic [1:0]                     cut_cnt_ff, cut_cnt_in;
   logic [CNT_W-1:0]               iss_j_ff, iss_j_in;
   logic                           iss_done_ff, iss_done_in;
   logic [ADDR_W-1:0]              rd_slot_ff, rd_slot_in;

   // result of the current item
   logic                           dpass_ff, dpass_in;
   logic                           res_pair_ff, res_pair_in;
   logic [dct_pkg::GAP_W-1:0]      res_gap_ff, res_gap_in;
   logic [dct_pkg::BACK_W-1:0]     res_back_ff, res_back_in;
   logic [dct_pkg::HITS_W-1:0]     res_hits_ff, res_hits_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_dpass_ff, rsp_dpass_in;
   logic                           rsp_pair_ff, rsp_pair_in;
   logic [dct_pkg::GAP_W-1:0]      rsp_gap_ff, rsp_gap_in;
   logic [dct_pkg::BACK_W-1:0]     rsp_back_ff, rsp_back_in;
   logic [dct_pkg::HITS_W-1:0]     rsp_hits_ff, rsp_hits_in;

   // walk pipeline
   logic                           s1_vld_ff, s1_vld_in;
   logic [CNT_W-1:0]               s1_j_ff;
   logic                           s2_vld_ff, s2_vld_in;
   logic [CNT_W-1:0]               s2_j_ff;
   dct_pkg::event_type             s2_ev_ff, s2_ev_in;
   logic [CLOCK_BITS-1:0]          s2_gap_ff, s2_gap_in;
   dct_pkg::vec_type               s2_diff_ff, s2_diff_in;
   logic                           s3_vld_ff, s3_vld_in;
   logic [CNT_W-1:0]               s3_j_ff;
   dct_pkg::cand_type              s3_cand_ff, s3_cand_in;
   logic [CLOCK_BITS-1:0]          s3_gap_ff;
   logic                           s4_vld_ff, s4_vld_in;
   logic [CNT_W-1:0]               s4_j_ff;
   dct_pkg::cand_type              s4_cand_ff;
   logic [CLOCK_BITS-1:0]          s4_gap_ff;

   // ram ports
   logic                           ram_we;
   logic [ENTRY_W-1:0]             ram_wdata;
   logic [ENTRY_W-1:0]             ram_rdata;
   dct_pkg::event_type             rd_ev;
   logic [CLOCK_BITS-1:0]          rd_clk;

   // sphere units
   dct_pkg::vec_type               sph_a_vec;
   logic                           sph_a_inside;
   logic                           sph_b_inside;

   // control terms
   logic                           accept;
   logic                           load;
   logic                           issue;
   logic                           walk_go;
   logic                           ret_hit;
   logic                           ret_stop;
   logic                           ret_last;
   logic                           finish;
   logic                           dpass_now;

   assign accept = req.valid && (state_ff == ST_IDLE);
   assign load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign issue  = (state_ff == ST_WALK) && !iss_done_ff;

   // ring memory: clock count above the packed event
   assign ram_we    = load;
   assign ram_wdata = {cur_clk_ff, cur_ev_ff};

   dct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) ring_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wslot_ff),
      .wr_data (ram_wdata),
      .rd_addr (rd_slot_ff),
      .rd_data (ram_rdata)
   );

   assign rd_ev  = dct_pkg::event_type'(ram_rdata[dct_pkg::EVENT_W-1:0]);
   assign rd_clk = ram_rdata[ENTRY_W-1 -: CLOCK_BITS];

   // radius check: current event during the cut, candidate during the walk
   always_comb begin
      if (state_ff == ST_CUT) begin
         sph_a_vec.x = dct_pkg::VEC_W'(cur_ev_ff.x);
         sph_a_vec.y = dct_pkg::VEC_W'(cur_ev_ff.y);
         sph_a_vec.z = dct_pkg::VEC_W'(cur_ev_ff.z);
      end else begin
         sph_a_vec.x = dct_pkg::VEC_W'(s2_ev_ff.x);
         sph_a_vec.y = dct_pkg::VEC_W'(s2_ev_ff.y);
         sph_a_vec.z = dct_pkg::VEC_W'(s2_ev_ff.z);
      end
   end

   dct_sphere radius_chk (
      .clock    (clock),
      .vec      (sph_a_vec),
      .limit    (cfg_ff.radius_limit),
      .in_reach (sph_a_inside)
   );

   // prompt to delayed distance check
   dct_sphere distance_chk (
      .clock    (clock),
      .vec      (s2_diff_ff),
      .limit    (cfg_ff.distance_limit),
      .in_reach (sph_b_inside)
   );

   // delayed cut of the current event
   assign dpass_now = cur_ev_ff.valid
                   && (cur_ev_ff.hits >= cfg_ff.delayed_hits_min)
                   && (cur_ev_ff.hits <= cfg_ff.delayed_hits_max)
                   && sph_a_inside;

   // retire stage of the walk
   assign ret_stop = s4_vld_ff && s4_cand_ff.valid && s4_cand_ff.beyond;
   assign ret_hit  = s4_vld_ff && s4_cand_ff.valid && !s4_cand_ff.beyond
                  && s4_cand_ff.hits_ok && sph_a_inside && !s4_cand_ff.too_soon
                  && sph_b_inside;
   assign ret_last = s4_vld_ff && (s4_j_ff == limit_ff);
   assign finish   = (state_ff == ST_WALK) && (ret_hit || ret_stop || ret_last);
   assign walk_go  = (state_ff == ST_WALK) && !finish;

   // pipeline stage 1: ram data arrives, gap and position differences
   always_comb begin
      s2_ev_in     = rd_ev;
      s2_gap_in    = cur_clk_ff - rd_clk;
      s2_diff_in.x = dct_pkg::VEC_W'(cur_ev_ff.x) - dct_pkg::VEC_W'(rd_ev.x);
      s2_diff_in.y = dct_pkg::VEC_W'(cur_ev_ff.y) - dct_pkg::VEC_W'(rd_ev.y);
      s2_diff_in.z = dct_pkg::VEC_W'(cur_ev_ff.z) - dct_pkg::VEC_W'(rd_ev.z);
   end

   // pipeline stage 2: delay and hit window compares
   always_comb begin
      s3_cand_in.valid    = s2_ev_ff.valid;
      s3_cand_in.beyond   = CMP_W'(s2_gap_ff) > CMP_W'(cfg_ff.delay_max_ticks);
      s3_cand_in.too_soon = CMP_W'(s2_gap_ff) < CMP_W'(cfg_ff.delay_min_ticks);
      s3_cand_in.hits_ok  = (s2_ev_ff.hits >= cfg_ff.prompt_hits_min)
                         && (s2_ev_ff.hits <= cfg_ff.prompt_hits_max);
      s3_cand_in.hits     = s2_ev_ff.hits;
   end

   // pipeline valids drop as soon as the walk ends
   assign s1_vld_in = walk_go && issue;
   assign s2_vld_in = walk_go && s1_vld_ff;
   assign s3_vld_in = walk_go && s2_vld_ff;
   assign s4_vld_in = walk_go && s3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_j_ff    <= iss_j_ff;
      s2_j_ff    <= s1_j_ff;
      s2_ev_ff   <= s2_ev_in;
      s2_gap_ff  <= s2_gap_in;
      s2_diff_ff <= s2_diff_in;
      s3_j_ff    <= s2_j_ff;
      s3_cand_ff <= s3_cand_in;
      s3_gap_ff  <= s2_gap_ff;
      s4_j_ff    <= s3_j_ff;
      s4_cand_ff <= s3_cand_ff;
      s4_gap_ff  <= s3_gap_ff;
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dct_pkg::CSR_PROMPT_HITS_MIN:
               cfg_in.prompt_hits_min  = csr_wdata[dct_pkg::HITS_W-1:0];
            dct_pkg::CSR_PROMPT_HITS_MAX:
               cfg_in.prompt_hits_max  = csr_wdata[dct_pkg::HITS_W-1:0];
            dct_pkg::CSR_DELAYED_HITS_MIN:
               cfg_in.delayed_hits_min = csr_wdata[dct_pkg::HITS_W-1:0];
            dct_pkg::CSR_DELAYED_HITS_MAX:
               cfg_in.delayed_hits_max = csr_wdata[dct_pkg::HITS_W-1:0];
            dct_pkg::CSR_RADIUS_LIMIT:
               cfg_in.radius_limit     = csr_wdata[dct_pkg::LIM_W-1:0];
            dct_pkg::CSR_DISTANCE_LIMIT:
               cfg_in.distance_limit   = csr_wdata[dct_pkg::LIM_W-1:0];
            dct_pkg::CSR_DELAY_MIN_TICKS:
               cfg_in.delay_min_ticks  = csr_wdata[dct_pkg::TICK_W-1:0];
            dct_pkg::CSR_DELAY_MAX_TICKS:
               cfg_in.delay_max_ticks  = csr_wdata[dct_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture of the accepted item
   always_comb begin
      cur_ev_in  = cur_ev_ff;
      cur_clk_in = cur_clk_ff;
      if (accept) begin
         cur_ev_in.valid = req.fit_valid;
         cur_ev_in.hits  = req.hit_count;
         cur_ev_in.x     = req.pos_x;
         cur_ev_in.y     = req.pos_y;
         cur_ev_in.z     = req.pos_z;
         cur_clk_in      = CLOCK_BITS'(req.clock_ticks);
      end
   end

   always_ff @(posedge clock) begin
      cur_ev_ff  <= cur_ev_in;
      cur_clk_ff <= cur_clk_in;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      wslot_in     = wslot_ff;
      fill_in      = fill_ff;
      limit_in     = limit_ff;
      cut_cnt_in   = 2'd0;
      iss_j_in     = iss_j_ff;
      iss_done_in  = iss_done_ff;
      rd_slot_in   = rd_slot_ff;
      dpass_in     = dpass_ff;
      res_pair_in  = res_pair_ff;
      res_gap_in   = res_gap_ff;
      res_back_in  = res_back_ff;
      res_hits_in  = res_hits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_dpass_in = rsp_dpass_ff;
      rsp_pair_in  = rsp_pair_ff;
      rsp_gap_in   = rsp_gap_ff;
      rsp_back_in  = rsp_back_ff;
      rsp_hits_in  = rsp_hits_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_CUT;
               limit_in    = (fill_ff < CNT_W'(SEARCH_LIMIT)) ? fill_ff : CNT_W'(SEARCH_LIMIT);
               iss_j_in    = CNT_W'(1);
               iss_done_in = 1'b0;
               rd_slot_in  = (wslot_ff == '0) ? ADDR_W'(RING_DEPTH - 1) : wslot_ff - 1'b1;
            end
         end

         // wait for the radius check of the current event
         ST_CUT: begin
            cut_cnt_in = cut_cnt_ff + 2'd1;
            if (cut_cnt_ff == 2'd2) begin
               cut_cnt_in  = 2'd0;
               dpass_in    = dpass_now;
               res_pair_in = 1'b0;
               res_gap_in  = '0;
               res_back_in = '0;
               res_hits_in = '0;
               state_in    = (dpass_now && (limit_ff != '0)) ? ST_WALK : ST_DONE;
            end
         end

         // one ring read per cycle, newest first
         ST_WALK: begin
            if (issue) begin
               if (iss_j_ff == limit_ff) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_j_in = iss_j_ff + 1'b1;
               end
               rd_slot_in = (rd_slot_ff == '0) ? ADDR_W'(RING_DEPTH - 1)
                                               : rd_slot_ff - 1'b1;
            end
            if (finish) begin
               state_in = ST_DONE;
               if (ret_hit) begin
                  res_pair_in = 1'b1;
                  res_gap_in  = dct_pkg::GAP_W'(s4_gap_ff);
                  res_back_in = dct_pkg::BACK_W'(s4_j_ff);
                  res_hits_in = s4_cand_ff.hits;
               end
            end
         end

         // hand over the result and store the event
         ST_DONE: begin
            if (load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_dpass_in = dpass_ff;
               rsp_pair_in  = res_pair_ff;
               rsp_gap_in   = res_gap_ff;
               rsp_back_in  = res_back_ff;
               rsp_hits_in  = res_hits_ff;
               wslot_in     = (wslot_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : wslot_ff + 1'b1;
               if (fill_ff < CNT_W'(RING_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= dct_pkg::CFG_RESET;
         wslot_ff     <= '0;
         fill_ff      <= '0;
         limit_ff     <= '0;
         cut_cnt_ff   <= 2'd0;
         iss_j_ff     <= '0;
         iss_done_ff  <= 1'b1;
         rd_slot_ff   <= '0;
         dpass_ff     <= 1'b0;
         res_pair_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         wslot_ff     <= wslot_in;
         fill_ff      <= fill_in;
         limit_ff     <= limit_in;
         cut_cnt_ff   <= cut_cnt_in;
         iss_j_ff     <= iss_j_in;
         iss_done_ff  <= iss_done_in;
         rd_slot_ff   <= rd_slot_in;
         dpass_ff     <= dpass_in;
         res_pair_ff  <= res_pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      res_gap_ff   <= res_gap_in;
      res_back_ff  <= res_back_in;
      res_hits_ff  <= res_hits_in;
      rsp_dpass_ff <= rsp_dpass_in;
      rsp_pair_ff  <= rsp_pair_in;
      rsp_gap_ff   <= rsp_gap_in;
      rsp_back_ff  <= rsp_back_in;
      rsp_hits_ff  <= rsp_hits_in;
   end

   // channel outputs
   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.delayed_passed = rsp_dpass_ff;
   assign rsp.pair_found     = rsp_pair_ff;
   assign rsp.gap_ticks      = rsp_gap_ff;
   assign rsp.events_back    = rsp_back_ff;
   assign rsp.prompt_hits    = rsp_hits_ff;

`ifndef NO_ASSERTIONS
   // a pair is only reported for an event that passed the delayed cuts
   a_pair_needs_dpass : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_pair_ff || rsp_dpass_ff))
      else $error("pair reported for an event that failed the delayed cuts");

   // one item in work at a time
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second item accepted while one is in work");

   // the retire stage only carries candidates during a walk
   a_retire_in_walk : assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (state_ff == ST_WALK))
      else $error("walk pipeline busy outside of a walk");

   // the fill count saturates at the ring depth
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(RING_DEPTH))
      else $error("fill count beyond ring depth");
`endif

endmodule

`default_nettype wire

### src/dct_ram.sv
// ---------------------------------------------------------------------------
// dct_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module dct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/dct_sphere.sv
// ---------------------------------------------------------------------------
// dct_sphere
// two-stage check that a vector lies within a radius, compared squared
// ---------------------------------------------------------------------------
`default_nettype none

module dct_sphere (
   input  wire logic                        clock,
   input  wire dct_pkg::vec_type            vec,
   input  wire logic [dct_pkg::LIM_W-1:0]   limit,
   output logic                             in_reach
);

   logic signed [2*dct_pkg::VEC_W-1:0] prod_x;
   logic signed [2*dct_pkg::VEC_W-1:0] prod_y;
   logic signed [2*dct_pkg::VEC_W-1:0] prod_z;
   logic [2*dct_pkg::LIM_W-1:0]        lim_prod;
   logic [dct_pkg::SQ_W-1:0]           sq_x_ff;
   logic [dct_pkg::SQ_W-1:0]           sq_y_ff;
   logic [dct_pkg::SQ_W-1:0]           sq_z_ff;
   logic [2*dct_pkg::LIM_W-1:0]        lim_sq_ff;
   logic [dct_pkg::SUM_W-1:0]          sum;
   logic                               in_reach_ff;
   logic                               in_reach_in;

   // squares, each component stays below 2^14 in magnitude
   assign prod_x   = vec.x * vec.x;
   assign prod_y   = vec.y * vec.y;
   assign prod_z   = vec.z * vec.z;
   assign lim_prod = limit * limit;

   always_ff @(posedge clock) begin
      sq_x_ff   <= prod_x[dct_pkg::SQ_W-1:0];
      sq_y_ff   <= prod_y[dct_pkg::SQ_W-1:0];
      sq_z_ff   <= prod_z[dct_pkg::SQ_W-1:0];
      lim_sq_ff <= lim_prod;
   end

   // sum and compare
   assign sum = dct_pkg::SUM_W'(sq_x_ff) + dct_pkg::SUM_W'(sq_y_ff)
              + dct_pkg::SUM_W'(sq_z_ff);
   assign in_reach_in = (sum <= dct_pkg::SUM_W'(lim_sq_ff));

   always_ff @(posedge clock) begin
      in_reach_ff <= in_reach_in;
   end

   assign in_reach = in_reach_ff;

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// delayed coincidence tagger: events are streamed through the item channel
// with random gaps and receiver stalls, every result is predicted by an
// event history model kept here and compared field by field, and the cuts
// are rewritten between phases while the block is idle
// ---------------------------------------------------------------------------

module testbench;
   import dct_pkg::*;

   localparam int RING_DEPTH   = 128;
   localparam int SEARCH_LIMIT = 102;
   localparam int HOLD_CYCLES  = 600;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd11;

   typedef struct packed {
      event_type             ev;
      logic [IN_CLK_W-1:0]   ticks;
   } det_event;

   typedef struct packed {
      logic                  delayed_passed;
      logic                  pair_found;
      logic [GAP_W-1:0]      gap_ticks;
      logic [BACK_W-1:0]     events_back;
      logic [HITS_W-1:0]     prompt_hits;
   } tag_result;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dct_req_if req_ch ();
   dct_rsp_if rsp_ch ();

   delayed_coincidence_tagger_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // cuts and event history as the block should hold them
   cfg_type                tag_cfg;
   logic [IN_CLK_W-1:0]    hist_ticks [RING_DEPTH];
   event_type              hist_event [RING_DEPTH];
   int                     hist_slot = 0;
   int                     hist_fill = 0;

   det_event               pending_events [$];
   tag_result              expected_tags [$];
   int                     errors = 0;
   int                     queued = 0;
   logic [IN_CLK_W-1:0]    stim_clk = '0;

   logic                   req_fire = 1'b0;
   logic                   rsp_fire = 1'b0;
   int                     send_wait = 0;
   int                     recv_wait = 0;
   int                     recv_hold = 0;
   bit                     send_burst = 0;
   bit                     recv_burst = 0;
   int                     hold_asks = 0;
   int                     hold_seen = 0;

   // squared radius against the fiducial limit
   function automatic logic in_fiducial(input logic signed [POS_W-1:0] x,
                                        input logic signed [POS_W-1:0] y,
                                        input logic signed [POS_W-1:0] z);
      longint r2, lim;
      r2  = longint'(x) * longint'(x) + longint'(y) * longint'(y)
          + longint'(z) * longint'(z);
      lim = longint'(tag_cfg.radius_limit);
      return r2 <= lim * lim;
   endfunction

   // tag one event, walk the history for a prompt partner, then store it
   function automatic tag_result tag_event(input det_event e);
      tag_result           r;
      int                  limit, slot;
      logic [IN_CLK_W-1:0] gap;
      event_type           p;
      longint              ex, ey, ez, d2, dl;
      bit                  done;
      r = '0;
      done = 0;
      r.delayed_passed = e.ev.valid && e.ev.hits >= tag_cfg.delayed_hits_min
                         && e.ev.hits <= tag_cfg.delayed_hits_max
                         && in_fiducial(e.ev.x, e.ev.y, e.ev.z);
      if (r.delayed_passed) begin
         limit = (hist_fill < SEARCH_LIMIT) ? hist_fill : SEARCH_LIMIT;
         dl = longint'(tag_cfg.distance_limit);
         for (int j = 1; j <= limit && !done; j++) begin
            slot = (hist_slot + RING_DEPTH - j) % RING_DEPTH;
            p = hist_event[slot];
            if (p.valid) begin
               gap = e.ticks - hist_ticks[slot];
               if (gap > tag_cfg.delay_max_ticks) begin
                  done = 1;
               end else if (p.hits >= tag_cfg.prompt_hits_min
                            && p.hits <= tag_cfg.prompt_hits_max
                            && in_fiducial(p.x, p.y, p.z)
                            && gap >= tag_cfg.delay_min_ticks) begin
                  ex = longint'(e.ev.x) - longint'(p.x);
                  ey = longint'(e.ev.y) - longint'(p.y);
                  ez = longint'(e.ev.z) - longint'(p.z);
                  d2 = ex * ex + ey * ey + ez * ez;
                  if (d2 <= dl * dl) begin
                     r.pair_found  = 1'b1;
                     r.gap_ticks   = gap;
                     r.events_back = BACK_W'(j);
                     r.prompt_hits = p.hits;
                     done = 1;
                  end
               end
            end
         end
      end
      hist_ticks[hist_slot] = e.ticks;
      hist_event[hist_slot] = e.ev;
      hist_slot = (hist_slot + 1) % RING_DEPTH;
      if (hist_fill < RING_DEPTH)
         hist_fill++;
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PROMPT_HITS_MIN:  tag_cfg.prompt_hits_min  = data[HITS_W-1:0];
         CSR_PROMPT_HITS_MAX:  tag_cfg.prompt_hits_max  = data[HITS_W-1:0];
         CSR_DELAYED_HITS_MIN: tag_cfg.delayed_hits_min = data[HITS_W-1:0];
         CSR_DELAYED_HITS_MAX: tag_cfg.delayed_hits_max = data[HITS_W-1:0];
         CSR_RADIUS_LIMIT:     tag_cfg.radius_limit     = data[LIM_W-1:0];
         CSR_DISTANCE_LIMIT:   tag_cfg.distance_limit   = data[LIM_W-1:0];
         CSR_DELAY_MIN_TICKS:  tag_cfg.delay_min_ticks  = data[TICK_W-1:0];
         CSR_DELAY_MAX_TICKS:  tag_cfg.delay_max_ticks  = data[TICK_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // item acceptance and result checking at the rising edge
   always @(posedge clock) begin : watch
      det_event  acc;
      tag_result want;
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      rsp_fire <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_tags.size() == 0) begin
            $display("%0t mismatch result expected none actual passed=%0b pair=%0b",
                     $time, rsp_ch.delayed_passed, rsp_ch.pair_found);
            errors++;
         end else begin
            want = expected_tags.pop_front();
            check_field("delayed_passed", want.delayed_passed, rsp_ch.delayed_passed);
            check_field("pair_found", want.pair_found, rsp_ch.pair_found);
            check_field("gap_ticks", want.gap_ticks, rsp_ch.gap_ticks);
            check_field("events_back", want.events_back, rsp_ch.events_back);
            check_field("prompt_hits", want.prompt_hits, rsp_ch.prompt_hits);
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         acc.ev.valid = req_ch.fit_valid;
         acc.ev.hits  = req_ch.hit_count;
         acc.ev.x     = req_ch.pos_x;
         acc.ev.y     = req_ch.pos_y;
         acc.ev.z     = req_ch.pos_z;
         acc.ticks    = req_ch.clock_ticks;
         expected_tags = {expected_tags, tag_event(acc)};
      end
   end

   // event driver: next item from the pending queue after a random gap
   always @(negedge clock) begin : feed
      det_event nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !req_fire)) begin
         if (send_wait > 0) begin
            send_wait--;
            req_ch.valid <= 1'b0;
         end else if (pending_events.size() > 0) begin
            nxt = pending_events.pop_front();
            req_ch.fit_valid   <= nxt.ev.valid;
            req_ch.hit_count   <= nxt.ev.hits;
            req_ch.pos_x       <= nxt.ev.x;
            req_ch.pos_y       <= nxt.ev.y;
            req_ch.pos_z       <= nxt.ev.z;
            req_ch.clock_ticks <= nxt.ticks;
            req_ch.valid       <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               send_burst = !send_burst;
            send_wait = send_burst ? 0 : $urandom_range(0, 6);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stall per item, long hold on request
   always @(negedge clock) begin : drain
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            recv_hold = HOLD_CYCLES;
         end
         if (rsp_fire) begin
            if ($urandom_range(0, 39) == 0)
               recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 6);
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      apply_reg(idx, data);
   endtask

   task automatic write_cuts(input cfg_type c);
      write_reg(CSR_PROMPT_HITS_MIN, CSR_DATA_W'(c.prompt_hits_min));
      write_reg(CSR_PROMPT_HITS_MAX, CSR_DATA_W'(c.prompt_hits_max));
      write_reg(CSR_DELAYED_HITS_MIN, CSR_DATA_W'(c.delayed_hits_min));
      write_reg(CSR_DELAYED_HITS_MAX, CSR_DATA_W'(c.delayed_hits_max));
      write_reg(CSR_RADIUS_LIMIT, CSR_DATA_W'(c.radius_limit));
      write_reg(CSR_DISTANCE_LIMIT, CSR_DATA_W'(c.distance_limit));
      write_reg(CSR_DELAY_MIN_TICKS, CSR_DATA_W'(c.delay_min_ticks));
      write_reg(CSR_DELAY_MAX_TICKS, CSR_DATA_W'(c.delay_max_ticks));
   endtask

   // wait until every item has gone in and every result has come back
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_events.size() != 0 || expected_tags.size() != 0 || req_ch.valid);
   endtask

   task automatic offer(input logic fit, input int hits, input int x, input int y,
                        input int z, input logic [IN_CLK_W-1:0] ticks);
      det_event e;
      e.ev.valid = fit;
      e.ev.hits  = hits[HITS_W-1:0];
      e.ev.x     = x[POS_W-1:0];
      e.ev.y     = y[POS_W-1:0];
      e.ev.z     = z[POS_W-1:0];
      e.ticks    = ticks;
      pending_events = {pending_events, e};
      queued++;
   endtask

   // value inside a window, edges favored; anything when the window is empty
   function automatic int pick_in(input int lo, input int hi, input int top);
      int k;
      if (lo > hi)
         return $urandom_range(0, top);
      k = $urandom_range(0, 9);
      if (k == 0)
         return lo;
      if (k == 1)
         return hi;
      return $urandom_range(hi, lo);
   endfunction

   function automatic int near(input int c, input int spread);
      int v;
      v = c + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 8191)
         v = 8191;
      if (v < -8192)
         v = -8192;
      return v;
   endfunction

   // prompt, some filler events, then a delayed candidate
   task automatic queue_pair(input int fillers, input int filler_valid_pct);
      int                  cx, cy, cz, spread, gap, pick;
      logic [IN_CLK_W-1:0] t0;
      cx = near(0, int'(tag_cfg.radius_limit) / 2);
      cy = near(0, int'(tag_cfg.radius_limit) / 2);
      cz = near(0, int'(tag_cfg.radius_limit) / 2);
      t0 = stim_clk + $urandom_range(1, 3000);
      offer($urandom_range(0, 19) != 0,
            pick_in(tag_cfg.prompt_hits_min, tag_cfg.prompt_hits_max, 4095),
            cx, cy, cz, t0);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         gap = (tag_cfg.delay_min_ticks > 0) ? int'(tag_cfg.delay_min_ticks) - 1 : 0;
      else if (pick == 1)
         gap = int'(tag_cfg.delay_max_ticks) + 1;
      else
         gap = pick_in(tag_cfg.delay_min_ticks, tag_cfg.delay_max_ticks, 50000);
      for (int i = 0; i < fillers; i++)
         offer($urandom_range(0, 99) < filler_valid_pct, $urandom_range(0, 4095),
               near(cx, 3000), near(cy, 3000), near(cz, 3000),
               t0 + $urandom_range(0, gap));
      spread = ($urandom_range(0, 1) != 0) ? int'(tag_cfg.distance_limit) / 2
                                           : int'(tag_cfg.distance_limit);
      stim_clk = t0 + gap;
      offer($urandom_range(0, 19) != 0,
            pick_in(tag_cfg.delayed_hits_min, tag_cfg.delayed_hits_max, 4095),
            near(cx, spread), near(cy, spread), near(cz, spread), stim_clk);
   endtask

   // fully random event, clock either stepped or thrown anywhere
   task automatic queue_noise();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      if ($urandom_range(0, 1) != 0)
         stim_clk = wide[IN_CLK_W-1:0];
      else
         stim_clk = stim_clk + $urandom_range(0, 60000);
      offer($urandom_range(0, 1) != 0, $urandom_range(0, 4095),
            int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192,
            int'($urandom_range(0, 16383)) - 8192, stim_clk);
   endtask

   task automatic queue_random(input int n);
      int target, k;
      target = queued + n;
      while (queued < target) begin
         k = $urandom_range(0, 99);
         if (k < 15)
            queue_noise();
         else if (k < 16)
            // long walk straddling the search limit
            queue_pair($urandom_range(99, 104), 10);
         else
            queue_pair($urandom_range(0, 4), 50);
      end
   endtask

   task automatic write_random_cuts();
      cfg_type c;
      c.prompt_hits_min  = HITS_W'($urandom_range(0, 600));
      c.prompt_hits_max  = HITS_W'($urandom_range(300, 4095));
      c.delayed_hits_min = HITS_W'($urandom_range(0, 600));
      c.delayed_hits_max = HITS_W'($urandom_range(300, 4095));
      c.radius_limit     = LIM_W'($urandom_range(1000, 8191));
      c.distance_limit   = LIM_W'($urandom_range(0, 8191));
      c.delay_min_ticks  = TICK_W'($urandom_range(0, 5000));
      c.delay_max_ticks  = TICK_W'($urandom_range(0, 100000));
      write_cuts(c);
   endtask

   localparam logic [IN_CLK_W-1:0] T0 = 43'd1000000;

   initial begin : stimulus
      cfg_type wide_open, shut;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.fit_valid = 1'b0;
      req_ch.hit_count = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      req_ch.clock_ticks = '0;
      rsp_ch.ready = 1'b0;
      tag_cfg = CFG_RESET;
      wide_open = '{prompt_hits_min: 12'd0, prompt_hits_max: 12'd4095,
                    delayed_hits_min: 12'd0, delayed_hits_max: 12'd4095,
                    radius_limit: 13'd8191, distance_limit: 13'd8191,
                    delay_min_ticks: 20'd0, delay_max_ticks: 20'hFFFFF};
      shut = '{prompt_hits_min: 12'd4095, prompt_hits_max: 12'd0,
               delayed_hits_min: 12'd0, delayed_hits_max: 12'd0,
               radius_limit: 13'd0, distance_limit: 13'd0,
               delay_min_ticks: 20'hFFFFF, delay_max_ticks: 20'd0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default cuts, unmapped index must change nothing
      write_reg(CSR_UNMAPPED, '1);
      write_cuts(CFG_RESET);

      // delayed candidate with an empty history
      offer(1, 400, 0, 0, 0, T0);
      // prompt at the lowest hit count, delayed at exactly the minimum gap
      offer(1, 120, 0, 0, 0, T0 + 100);
      offer(1, 350, 1000, 0, 0, T0 + 120);
      // invalid fit skipped, too-soon candidate passed over
      offer(0, 400, 0, 0, 0, T0 + 125);
      offer(1, 600, 0, 0, 0, T0 + 130);
      // field extremes, outside every cut
      offer(1, 4095, 8191, -8192, 8191, T0 + 140);
      offer(0, 0, -8192, 8191, -8192, T0 + 150);
      // prompt on the radius edge at the highest count, gap exactly the maximum
      offer(1, 680, 5700, 0, 0, T0 + 1000);
      offer(1, 500, 5700, 0, 0, T0 + 41000);
      // walk ends on a gap one beyond the maximum
      offer(1, 450, 5700, 0, 0, T0 + 41001);
      // just outside the radius
      offer(1, 400, 5701, 0, 0, T0 + 41010);
      // distance exactly at the limit, then one beyond it
      offer(1, 300, 0, 0, -3000, T0 + 200000);
      offer(1, 400, 0, 0, -1500, T0 + 200100);
      offer(1, 400, 0, 0, -4501, T0 + 200200);
      // hit counts just outside the delayed window
      offer(1, 349, 0, 0, 0, T0 + 200300);
      offer(1, 601, 0, 0, 0, T0 + 200400);
      // prompt count just above its window
      offer(1, 681, 0, 0, 0, T0 + 300000);
      offer(1, 400, 0, 0, 0, T0 + 300050);
      // clock wrap between prompt and delayed
      offer(1, 300, 100, 100, 100, 43'h7FF_FFFF_FFF6);
      offer(1, 400, 100, 100, 100, 43'd15);
      stim_clk = 43'd15;
      queue_random(230);
      wait_idle();

      // widest cuts, receiver holds off so the block backs up
      write_cuts(wide_open);
      queue_random(200);
      hold_asks++;
      wait_idle();

      // windows that pass nothing or only zero, and zero limits
      write_cuts(shut);
      queue_random(60);
      wait_idle();

      // raw register data, upper bits dropped by the register widths
      for (int i = CSR_PROMPT_HITS_MIN; i <= CSR_DELAY_MAX_TICKS; i++)
         write_reg(i[CSR_IDX_W-1:0], CSR_DATA_W'($urandom));
      queue_random(100);
      wait_idle();

      write_random_cuts();
      queue_random(150);
      wait_idle();

      // defaults again, sender pauses midway until all results are back
      write_cuts(CFG_RESET);
      queue_random(100);
      wait_idle();
      queue_random(100);
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0 && expected_tags.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
src/dct_pkg.sv
src/dct_req_if.sv
src/dct_rsp_if.sv
src/dct_ram.sv
src/dct_sphere.sv
src/delayed_coincidence_tagger_core.sv
test/testbench.sv
